FILE: src/lrm_pkg.sv
// ----------------------------------------------------------------------------
// lrm_pkg: shared types and constants for the link rate meter
// Field widths, transaction structs and the divider request/response groups.
// ----------------------------------------------------------------------------
`default_nettype none

package lrm_pkg;

	localparam int CNT_W      = 64;   // byte counter width
	localparam int ELAPSED_W  = 32;   // elapsed time / divisor width
	localparam int RATE_W     = 48;   // rate, average and quotient width
	localparam int PROD_W     = 77;   // delta * 8000 fits in 77 bits
	localparam int HI_W       = PROD_W - RATE_W;
	localparam int WINDOW_DEF = 10;

	// 8000 = 2^13 - 2^7 - 2^6
	localparam int MUL_SH_HI  = 13;
	localparam int MUL_SH_MID = 7;
	localparam int MUL_SH_LO  = 6;

	typedef struct packed {
		logic [CNT_W-1:0]     rx_total;
		logic [CNT_W-1:0]     tx_total;
		logic [ELAPSED_W-1:0] elapsed_ms;
	} in_item_t;

	typedef struct packed {
		logic [CNT_W-1:0]  rx_count_out;
		logic [CNT_W-1:0]  tx_count_out;
		logic [RATE_W-1:0] rx_rate;
		logic [RATE_W-1:0] tx_rate;
		logic [RATE_W-1:0] rx_avg;
		logic [RATE_W-1:0] tx_avg;
	} out_item_t;

	typedef struct packed {
		logic                 start;
		logic [PROD_W-1:0]    dividend;
		logic [ELAPSED_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [RATE_W-1:0] quotient;
	} div_rsp_t;

endpackage

`default_nettype wire

FILE: src/lrm_div.sv
// ----------------------------------------------------------------------------
// lrm_div: shared restoring divider
// Returns min(floor(dividend / divisor), 2^48 - 1), one quotient bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lrm_div
	import lrm_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);

	localparam int STEP_W = $clog2(RATE_W);

	logic                 busy_q;
	logic                 done_q;
	logic                 sat_q;
	logic [STEP_W-1:0]    step_q;
	logic [ELAPSED_W-1:0] rem_q;
	logic [ELAPSED_W-1:0] dvs_q;
	logic [RATE_W-1:0]    num_q;

	logic [HI_W-1:0]      hi;
	logic                 sat;
	logic [ELAPSED_W:0]   trial;
	logic [ELAPSED_W:0]   diff;
	logic                 ge;

	always_comb begin
		hi    = req.dividend[PROD_W-1:RATE_W];
		sat   = {{(ELAPSED_W-HI_W){1'b0}}, hi} >= req.divisor;
		trial = {rem_q, num_q[RATE_W-1]};
		diff  = trial - {1'b0, dvs_q};
		ge    = trial >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			sat_q  <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				// quotient too large for the field: finish at once
				busy_q <= !sat;
				done_q <= sat;
				sat_q  <= sat;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(RATE_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// quotient bits shift in at the bottom while dividend bits leave the top
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= {{(ELAPSED_W-HI_W){1'b0}}, hi};
			dvs_q <= req.divisor;
			num_q <= req.dividend[RATE_W-1:0];
		end else if (busy_q) begin
			rem_q <= ge ? diff[ELAPSED_W-1:0] : trial[ELAPSED_W-1:0];
			num_q <= {num_q[RATE_W-2:0], ge};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = sat_q ? {RATE_W{1'b1}} : num_q;

endmodule

`default_nettype wire

FILE: src/lrm_win.sv
// ----------------------------------------------------------------------------
// lrm_win: moving window of rates
// Holds the last WINDOW rx/tx rates in memory with running sums and fill level.
// ----------------------------------------------------------------------------
`default_nettype none

module lrm_win
	import lrm_pkg::*;
#(
	parameter int WINDOW = WINDOW_DEF,
	localparam int SUM_W  = RATE_W + $clog2(WINDOW + 1),
	localparam int FILL_W = $clog2(WINDOW + 1)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire logic [RATE_W-1:0] rx_rate,
	input  wire logic [RATE_W-1:0] tx_rate,
	output logic      [SUM_W-1:0]  rx_sum,
	output logic      [SUM_W-1:0]  tx_sum,
	output logic      [FILL_W-1:0] fill
);

	localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

	logic [RATE_W-1:0] rx_mem [WINDOW];
	logic [RATE_W-1:0] tx_mem [WINDOW];
	logic [RATE_W-1:0] rx_old_q;
	logic [RATE_W-1:0] tx_old_q;
	logic [SLOT_W-1:0] slot_q;
	logic [FILL_W-1:0] fill_q;
	logic [SUM_W-1:0]  rx_sum_q;
	logic [SUM_W-1:0]  tx_sum_q;
	logic              full;

	assign full = fill_q == FILL_W'(WINDOW);

	// slot holds still between pushes, so the registered read is current
	always_ff @(posedge clk) begin
		rx_old_q <= rx_mem[slot_q];
		tx_old_q <= tx_mem[slot_q];
		if (push) begin
			rx_mem[slot_q] <= rx_rate;
			tx_mem[slot_q] <= tx_rate;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q   <= '0;
			fill_q   <= '0;
			rx_sum_q <= '0;
			tx_sum_q <= '0;
		end else if (push) begin
			slot_q <= (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
			if (full) begin
				// drop the oldest rate
				rx_sum_q <= rx_sum_q - {{(SUM_W-RATE_W){1'b0}}, rx_old_q}
					+ {{(SUM_W-RATE_W){1'b0}}, rx_rate};
				tx_sum_q <= tx_sum_q - {{(SUM_W-RATE_W){1'b0}}, tx_old_q}
					+ {{(SUM_W-RATE_W){1'b0}}, tx_rate};
			end else begin
				fill_q   <= fill_q + 1'b1;
				rx_sum_q <= rx_sum_q + {{(SUM_W-RATE_W){1'b0}}, rx_rate};
				tx_sum_q <= tx_sum_q + {{(SUM_W-RATE_W){1'b0}}, tx_rate};
			end
		end
	end

	assign rx_sum = rx_sum_q;
	assign tx_sum = tx_sum_q;
	assign fill   = fill_q;

endmodule

`default_nettype wire

FILE: src/link_rate_meter_moving_average_unit.sv
// ----------------------------------------------------------------------------
// link_rate_meter_moving_average_unit: link rate meter with moving average
// Turns cumulative byte counters into bit rates and their windowed mean.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in      | input     | in_valid / in_ready    | in_item  (in_item_t)
//  out     | output    | out_valid / out_ready  | out_item (out_item_t)
//
//  A sample that yields a result passes two rates (two multiply steps,
//  divider start, the quotient bits, done), a push, two means and the
//  output state. A saturated rate skips the quotient bits. Baseline and
//  zero elapsed time samples end in idle. in_ready is high only in idle;
//  a result waits in the output register while the next sample runs, and
//  a held register stalls in ST_OUT. Reset clears the baseline, sums and
//  fill level; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module link_rate_meter_moving_average_unit
	import lrm_pkg::*;
#(
	parameter int WINDOW = WINDOW_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire in_item_t  in_item,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_item_t      out_item
);

	localparam int SUM_W  = RATE_W + $clog2(WINDOW + 1);
	localparam int FILL_W = $clog2(WINDOW + 1);

	typedef enum logic [8:0] {
		ST_IDLE     = 9'b000000001,
		ST_MUL_A    = 9'b000000010,
		ST_MUL_B    = 9'b000000100,
		ST_DIV_GO   = 9'b000001000,
		ST_DIV_WAIT = 9'b000010000,
		ST_PUSH     = 9'b000100000,
		ST_AVG_GO   = 9'b001000000,
		ST_AVG_WAIT = 9'b010000000,
		ST_OUT      = 9'b100000000
	} state_t;

	state_t               state_q;
	logic                 side_q;      // 0: rx, 1: tx
	logic                 base_q;
	logic [CNT_W-1:0]     prev_rx_q;
	logic [CNT_W-1:0]     prev_tx_q;
	logic [CNT_W-1:0]     drx_q;
	logic [CNT_W-1:0]     dtx_q;
	logic [ELAPSED_W-1:0] el_q;
	logic [PROD_W-1:0]    prod_q;
	logic [RATE_W-1:0]    rate_rx_q;
	logic [RATE_W-1:0]    rate_tx_q;
	logic [RATE_W-1:0]    avg_rx_q;
	logic [RATE_W-1:0]    avg_tx_q;
	logic                 out_valid_q;
	out_item_t            out_q;

	logic                 accept;
	logic                 out_free;
	logic [PROD_W-1:0]    dext;
	logic [SUM_W-1:0]     rx_sum;
	logic [SUM_W-1:0]     tx_sum;
	logic [FILL_W-1:0]    fill;
	logic [SUM_W-1:0]     sum_sel;
	div_req_t             div_req;
	div_rsp_t             div_rsp;

	assign in_ready = state_q == ST_IDLE;
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	assign dext    = {{(PROD_W-CNT_W){1'b0}}, side_q ? dtx_q : drx_q};
	assign sum_sel = side_q ? tx_sum : rx_sum;

	always_comb begin
		div_req.start    = (state_q == ST_DIV_GO) || (state_q == ST_AVG_GO);
		div_req.dividend = prod_q;
		div_req.divisor  = el_q;
		if (state_q == ST_AVG_GO) begin
			div_req.dividend = {{(PROD_W-SUM_W){1'b0}}, sum_sel};
			div_req.divisor  = {{(ELAPSED_W-FILL_W){1'b0}}, fill};
		end
	end

	lrm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	lrm_win #(
		.WINDOW (WINDOW)
	) u_win (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (state_q == ST_PUSH),
		.rx_rate (rate_rx_q),
		.tx_rate (rate_tx_q),
		.rx_sum  (rx_sum),
		.tx_sum  (tx_sum),
		.fill    (fill)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			side_q      <= 1'b0;
			base_q      <= 1'b0;
			prev_rx_q   <= '0;
			prev_tx_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (!base_q) begin
							base_q    <= 1'b1;
							prev_rx_q <= in_item.rx_total;
							prev_tx_q <= in_item.tx_total;
						end else if (in_item.elapsed_ms != '0) begin
							// the new counters become the baseline and the echo
							prev_rx_q <= in_item.rx_total;
							prev_tx_q <= in_item.tx_total;
							side_q    <= 1'b0;
							state_q   <= ST_MUL_A;
						end
					end
				end
				ST_MUL_A:  state_q <= ST_MUL_B;
				ST_MUL_B:  state_q <= ST_DIV_GO;
				ST_DIV_GO: state_q <= ST_DIV_WAIT;
				ST_DIV_WAIT: begin
					if (div_rsp.done) begin
						side_q  <= !side_q;
						state_q <= side_q ? ST_PUSH : ST_MUL_A;
					end
				end
				ST_PUSH:   state_q <= ST_AVG_GO;
				ST_AVG_GO: state_q <= ST_AVG_WAIT;
				ST_AVG_WAIT: begin
					if (div_rsp.done) begin
						side_q  <= !side_q;
						state_q <= side_q ? ST_OUT : ST_AVG_GO;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			drx_q <= in_item.rx_total - prev_rx_q;
			dtx_q <= in_item.tx_total - prev_tx_q;
			el_q  <= in_item.elapsed_ms;
		end
		// delta * 8000 as shifts and subtracts in ST_MUL_A and ST_MUL_B
		if (state_q == ST_MUL_A) begin
			prod_q <= (dext << MUL_SH_HI) - (dext << MUL_SH_MID);
		end
		if (state_q == ST_MUL_B) begin
			prod_q <= prod_q - (dext << MUL_SH_LO);
		end
		if (state_q == ST_DIV_WAIT && div_rsp.done) begin
			if (side_q) begin
				rate_tx_q <= div_rsp.quotient;
			end else begin
				rate_rx_q <= div_rsp.quotient;
			end
		end
		if (state_q == ST_AVG_WAIT && div_rsp.done) begin
			if (side_q) begin
				avg_tx_q <= div_rsp.quotient;
			end else begin
				avg_rx_q <= div_rsp.quotient;
			end
		end
		if (state_q == ST_OUT && out_free) begin
			out_q.rx_count_out <= prev_rx_q;
			out_q.tx_count_out <= prev_tx_q;
			out_q.rx_rate      <= rate_rx_q;
			out_q.tx_rate      <= rate_tx_q;
			out_q.rx_avg       <= avg_rx_q;
			out_q.tx_avg       <= avg_tx_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

`default_nettype wire
